// File: hdl/rsa_modexp_char_codec_defines.svh
// ----------------------------------------------------------------------------
// rsa_modexp_char_codec assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RSA_MODEXP_CHAR_CODEC_DEFINES_SVH
`define RSA_MODEXP_CHAR_CODEC_DEFINES_SVH
`ifndef SYNTH
`define RMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rmc assertion failed");
`define RMC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rmc assertion failed");
`else
`define RMC_ASSERT(lbl, prop)
`define RMC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hdl/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg
// Types and constants of the RSA character codec.
// ----------------------------------------------------------------------------
package rmc_pkg;

  localparam int MOD_BITS_DEF = 32;
  localparam int EXP_BITS     = 32;
  localparam int CODE_RADIX   = 94;
  localparam int CODE_OFFSET  = 33;
  localparam int MODULUS_RST  = 2;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_ENC_EXP = 2'd1,
    REG_DEC_EXP = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQR_GO,
    ST_SQR_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_FINISH,
    ST_SPLIT
  } state_e;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic [25:0] high_part;
  } rmc_in_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic [25:0] out_high;
  } rmc_out_t;

endpackage

// File: hdl/rmc_div.sv
// ----------------------------------------------------------------------------
// rmc_div
// Bit-serial restoring divider, one quotient bit per cycle; returns the
// remainder.
// ----------------------------------------------------------------------------
module rmc_div #(
  parameter int DW = 34,
  parameter int NW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] remainder_o
);

  localparam int CW = $clog2(DW);

  logic [DW-1:0] dvd_q;
  logic [NW-1:0] rem_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [NW:0]   trial;
  logic [NW:0]   diff;
  logic          qbit;

  always_comb begin
    trial = {rem_q, dvd_q[DW-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    diff  = qbit ? (trial - {1'b0, dvs_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(DW - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[DW-2:0], qbit};
      rem_q <= diff[NW-1:0];
    end
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q;

endmodule

// File: hdl/rmc_mulmod.sv
// ----------------------------------------------------------------------------
// rmc_mulmod
// Shift-and-add modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rmc_mulmod #(
  parameter int NW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] a_i,
  input  logic [NW-1:0] b_i,
  input  logic [NW-1:0] n_i,
  output logic          done_o,
  output logic [NW-1:0] product_o
);

  logic [NW-1:0] a_q, b_q, n_q, acc_q;
  logic          run_q, done_q;
  logic [NW-1:0] acc_add, a_dbl;

  // operands are below n
  function automatic logic [NW-1:0] add_mod(input logic [NW-1:0] x,
                                            input logic [NW-1:0] y,
                                            input logic [NW-1:0] m);
    logic [NW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[NW-1:0];
  endfunction

  always_comb begin
    acc_add = add_mod(acc_q, a_q, n_q);
    a_dbl   = add_mod(a_q, a_q, n_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && (b_q == '0)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      n_q   <= n_i;
      acc_q <= '0;
    end else if (run_q && (b_q != '0)) begin
      if (b_q[0]) acc_q <= acc_add;
      a_q <= a_dbl;
      b_q <= {1'b0, b_q[NW-1:1]};
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

// File: hdl/rsa_modexp_char_codec.sv
// ----------------------------------------------------------------------------
// rsa_modexp_char_codec
// Textbook RSA on one character per command, square-and-multiply.
// ----------------------------------------------------------------------------
// Usage: write modulus, enc_exponent and dec_exponent through the cfg
// channel (index 0..2) while busy is low. A command beat is taken when
// start is high and busy is low; busy stays high until the result.
// Encrypt returns k mod 94 + 33 and k / 94 for k = byte^e mod n.
// Decrypt rebuilds c = 94 * high + char - 33 and returns (c^d mod n) & 0xFF.
// The result shows on result_o for exactly one cycle with done_o high;
// the receiver cannot stall it. Steps, W = max(MOD_BITS, 34):
//   operand reduction of the W-bit operand on the serial divider,
//   32 squarings and one multiply per set exponent bit on the shared
//   modular multiplier, one finish state,
//   encrypt then splits k by 94 over ceil(MOD_BITS / 8) bytes, one byte
//   per cycle; done_o follows, busy is already low in that cycle.
// A zero exponent goes from the reduction straight to the finish state.
// Reset: modulus 2, exponents 0, block idle, no result pending.
// ----------------------------------------------------------------------------
`include "rsa_modexp_char_codec_defines.svh"

module rsa_modexp_char_codec
  import rmc_pkg::*;
#(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  rmc_in_t     in_i,
  output logic        done_o,
  output rmc_out_t    result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int DW          = (MOD_BITS > 34) ? MOD_BITS : 34;
  localparam int BW          = $clog2(EXP_BITS);
  localparam int SPLIT_BYTES = (MOD_BITS + 7) / 8;
  localparam int KW          = SPLIT_BYTES * 8;
  localparam int SW          = $clog2(SPLIT_BYTES);
  // x / 47 == (x * RECIP_47) >> RECIP_SHIFT for x below 2^14
  localparam int RECIP_47    = 22311;
  localparam int RECIP_SHIFT = 20;

  logic [MOD_BITS-1:0] modulus_q, n_eff;
  logic [31:0]         enc_exp_q, dec_exp_q;

  state_e              state_q, state_d;
  logic                op_q, op_d, neg_q, neg_d;
  logic [MOD_BITS-1:0] n_q, n_d, base_q, base_d, acc_q, acc_d;
  logic [31:0]         exp_q, exp_d;
  logic [BW-1:0]       bit_q, bit_d;
  rmc_out_t            res_q, res_d;
  logic                done_q, done_d;
  logic [KW-1:0]       spl_q, spl_d;
  logic [6:0]          srem_q, srem_d;
  logic [SW-1:0]       scnt_q, scnt_d;

  logic                accept;
  logic [32:0]         scaled;
  logic [34:0]         sval;
  logic [33:0]         mag;
  logic [14:0]         spl_v;
  logic [27:0]         spl_prod;
  logic [7:0]          spl_digit;
  logic [6:0]          spl_rem;
  logic [KW-1:0]       spl_quo;

  logic                div_start, div_done;
  logic [DW-1:0]       div_dividend;
  logic [MOD_BITS-1:0] div_divisor, div_rem;
  logic                mul_start, mul_done;
  logic [MOD_BITS-1:0] mul_b, mul_prod;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy;
  assign n_eff       = (modulus_q < MOD_BITS'(2)) ? MOD_BITS'(1) : modulus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_BITS'(MODULUS_RST);
      enc_exp_q <= '0;
      dec_exp_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MODULUS: modulus_q <= MOD_BITS'(cfg_data_i);
        REG_ENC_EXP: enc_exp_q <= cfg_data_i;
        REG_DEC_EXP: dec_exp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // signed decrypt operand as sign and magnitude
  always_comb begin
    scaled = 33'(in_i.high_part) * 33'(CODE_RADIX);
    sval   = {2'b00, scaled} + 35'(in_i.data_byte) - 35'(CODE_OFFSET);
    if (in_i.operation == OP_DECRYPT) begin
      neg_d = sval[34];
      mag   = sval[34] ? 34'(35'd0 - sval) : sval[33:0];
    end else begin
      neg_d = 1'b0;
      mag   = 34'(in_i.data_byte);
    end
  end

  // one quotient byte by 94 per cycle: v = rem * 256 + next byte of k
  always_comb begin
    spl_v     = {srem_q, spl_q[KW-1 -: 8]};
    spl_prod  = 28'(spl_v[14:1]) * 28'(RECIP_47);
    spl_digit = spl_prod[RECIP_SHIFT +: 8];
    spl_rem   = 7'(spl_v - 15'(spl_digit) * 15'(CODE_RADIX));
    spl_quo   = {spl_q[KW-9:0], spl_digit};
  end

  assign div_start    = accept;
  assign div_dividend = DW'(mag);
  assign div_divisor  = n_eff;
  assign mul_start    = (state_q == ST_SQR_GO) || (state_q == ST_MUL_GO);
  assign mul_b        = (state_q == ST_SQR_GO) ? acc_q : base_q;

  rmc_div #(
    .DW(DW),
    .NW(MOD_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .remainder_o (div_rem)
  );

  rmc_mulmod #(
    .NW(MOD_BITS)
  ) u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (acc_q),
    .b_i       (mul_b),
    .n_i       (n_q),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    n_d     = n_q;
    exp_d   = exp_q;
    base_d  = base_q;
    acc_d   = acc_q;
    bit_d   = bit_q;
    res_d   = res_q;
    spl_d   = spl_q;
    srem_d  = srem_q;
    scnt_d  = scnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d    = in_i.operation;
          n_d     = n_eff;
          exp_d   = (in_i.operation == OP_DECRYPT) ? dec_exp_q : enc_exp_q;
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (div_done) begin
          base_d = (neg_q && (div_rem != '0)) ? (n_q - div_rem) : div_rem;
          bit_d  = BW'(EXP_BITS - 1);
          if (exp_q == '0) begin
            acc_d   = MOD_BITS'(1);
            state_d = ST_FINISH;
          end else begin
            acc_d   = (n_q == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
            state_d = ST_SQR_GO;
          end
        end
      end
      ST_SQR_GO: state_d = ST_SQR_WAIT;
      ST_SQR_WAIT: begin
        if (mul_done) begin
          acc_d = mul_prod;
          if (exp_q[bit_q]) begin
            state_d = ST_MUL_GO;
          end else if (bit_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            bit_d   = bit_q - BW'(1);
            state_d = ST_SQR_GO;
          end
        end
      end
      ST_MUL_GO: state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          acc_d = mul_prod;
          if (bit_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            bit_d   = bit_q - BW'(1);
            state_d = ST_SQR_GO;
          end
        end
      end
      ST_FINISH: begin
        if (op_q == OP_ENCRYPT) begin
          spl_d   = KW'(acc_q);
          srem_d  = '0;
          scnt_d  = SW'(SPLIT_BYTES - 1);
          state_d = ST_SPLIT;
        end else begin
          res_d.out_char = acc_q[7:0];
          res_d.out_high = '0;
          done_d         = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SPLIT: begin
        spl_d  = spl_quo;
        srem_d = spl_rem;
        scnt_d = scnt_q - SW'(1);
        if (scnt_q == '0) begin
          res_d.out_char = 8'(spl_rem) + 8'(CODE_OFFSET);
          res_d.out_high = 26'(spl_quo);
          done_d         = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    n_q    <= n_d;
    exp_q  <= exp_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
    spl_q  <= spl_d;
    srem_q <= srem_d;
    scnt_q <= scnt_d;
    if (accept) neg_q <= neg_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `RMC_ASSERT(a_done_idle, done_o |-> !busy)
  `RMC_ASSERT(a_start_busy, start && !busy |=> busy)
  `RMC_ASSERT(a_done_single, done_o |=> !done_o)
  `RMC_ASSERT(a_dec_high_zero, done_o && (op_q == OP_DECRYPT) |-> result_o.out_high == '0)
  `RMC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o)

endmodule
